// File: rtl/vertex_dedup_indexer_assert.svh
// Assertion macros for the vertex deduplication indexer.
`ifndef VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define VDI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex indexer assertion failed");
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertex indexer assertion failed");
`else
`define VDI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/vdi_pkg.sv
// Package of types and constants for the vertex deduplication indexer.
`default_nettype none
package vdi_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int INDEX_W = 10;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } vdi_vertex_t;

  typedef struct packed {
    logic        first_of_mesh;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } vdi_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               table_overflow;
  } vdi_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } vdi_state_t;

endpackage
`default_nettype wire

// File: rtl/vdi_table.sv
// Unique-vertex table memory: one write port, one registered read port.
`default_nettype none
module vdi_table
  import vdi_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire vdi_vertex_t      wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output vdi_vertex_t           rdata
);

  vdi_vertex_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/vdi_cmp.sv
// IEEE binary32 equality of all six words of two vertices.
`default_nettype none
module vdi_cmp
  import vdi_pkg::*;
(
  input  wire vdi_vertex_t a,
  input  wire vdi_vertex_t b,
  output logic             hit
);

  localparam logic [31:0] MagMask = 32'h7FFF_FFFF;
  localparam logic [31:0] InfBits = 32'h7F80_0000;

  // NaN never matches; +0 and -0 match each other.
  function automatic logic f32_eq(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] mx;
    logic [31:0] my;
    mx = x & MagMask;
    my = y & MagMask;
    if (mx > InfBits || my > InfBits) begin
      return 1'b0;
    end
    if (mx == '0 && my == '0) begin
      return 1'b1;
    end
    return x == y;
  endfunction

  assign hit = f32_eq(a.pos_x, b.pos_x) && f32_eq(a.pos_y, b.pos_y) &&
               f32_eq(a.pos_z, b.pos_z) && f32_eq(a.norm_x, b.norm_x) &&
               f32_eq(a.norm_y, b.norm_y) && f32_eq(a.norm_z, b.norm_z);

endmodule
`default_nettype wire

// File: rtl/vertex_dedup_indexer.sv
// Vertex deduplication indexer: scan controller, vertex table and result register.
`default_nettype none
`include "vertex_dedup_indexer_assert.svh"
// A request is taken when start is high and busy is low. The table memory is
// scanned one entry per cycle from entry 0 through its single read port, and a
// request resolves at the first matching entry or once every stored vertex has
// been compared. The result is registered and is on the result port for exactly
// one cycle with done high and cannot be held off; busy drops in that same
// cycle, so the next request may be taken while it is shown.
// first_of_mesh empties the table at once with no clearing pass.
module vertex_dedup_indexer
  import vdi_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire vdi_in_t request,
  output logic         done,
  output vdi_out_t     result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FullCount = CNT_W'(TABLE_DEPTH);

  vdi_state_t       state, state_next;
  logic [CNT_W-1:0] unique_count, unique_count_next;
  logic [CNT_W-1:0] addr, addr_next;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  vdi_vertex_t      vtx;
  vdi_vertex_t      rdata;
  logic             hit;
  logic             accept;
  logic             re;
  logic             we;
  logic             found;
  logic             missed;
  logic             full;
  logic             done_next;
  vdi_out_t         result_next;

  assign accept = start && !busy;
  assign full   = unique_count == FullCount;
  assign found  = pend && hit;
  assign missed = !pend && addr == unique_count;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found || missed) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    busy              = 1'b0;
    re                = 1'b0;
    we                = 1'b0;
    done_next         = 1'b0;
    result_next       = '0;
    addr_next         = addr;
    unique_count_next = unique_count;
    unique case (state)
      ST_IDLE: begin
        addr_next = '0;
        if (accept && request.first_of_mesh) begin
          unique_count_next = '0;
        end
      end
      ST_SCAN: begin
        busy = 1'b1;
        if (found) begin
          done_next                = 1'b1;
          result_next.vertex_index = INDEX_W'(pend_idx);
        end else if (missed) begin
          done_next = 1'b1;
          if (full) begin
            result_next.table_overflow = 1'b1;
          end else begin
            we                       = 1'b1;
            result_next.vertex_index = INDEX_W'(unique_count);
            result_next.is_new       = 1'b1;
            unique_count_next        = unique_count + CNT_W'(1);
          end
        end else if (addr < unique_count) begin
          // Issue the next read while earlier data is still being compared.
          re        = 1'b1;
          addr_next = addr + CNT_W'(1);
        end
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      unique_count <= '0;
      addr         <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      unique_count <= unique_count_next;
      addr         <= addr_next;
      pend         <= re;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (re) begin
      pend_idx <= addr[IDX_W-1:0];
    end
    if (accept) begin
      vtx.pos_x  <= request.pos_x;
      vtx.pos_y  <= request.pos_y;
      vtx.pos_z  <= request.pos_z;
      vtx.norm_x <= request.norm_x;
      vtx.norm_y <= request.norm_y;
      vtx.norm_z <= request.norm_z;
    end
  end

  vdi_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(unique_count[IDX_W-1:0]),
    .wdata(vtx),
    .re   (re),
    .raddr(addr[IDX_W-1:0]),
    .rdata(rdata)
  );

  vdi_cmp u_cmp (
    .a  (rdata),
    .b  (vtx),
    .hit(hit)
  );

  `VDI_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `VDI_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `VDI_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, unique_count <= FullCount)
  `VDI_ASSERT_IMPL(a_ovf_clean, clk, rst, done && result.table_overflow, !result.is_new && result.vertex_index == '0)
  `VDI_ASSERT_IMPL(a_scan_bound, clk, rst, busy, addr <= unique_count)

endmodule
`default_nettype wire
